// ----- sv/fractal_pixel_colour_mapper_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the fractal pixel colour mapper core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRACTAL_PIXEL_COLOUR_MAPPER_CORE_ASSERT_SVH
`define FRACTAL_PIXEL_COLOUR_MAPPER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check a property outside reset
`define FPCM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("fpcm assertion failed");
// check a property on every edge, reset included
`define FPCM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("fpcm assertion failed");
`else
`define FPCM_ASSERT(lbl, clk, rst_n, prop)
`define FPCM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- sv/fpcm_pkg.sv -----
// ----------------------------------------------------------------------------
// fpcm_pkg
// Types and constants shared by the fractal pixel colour mapper modules.
// ----------------------------------------------------------------------------
package fpcm_pkg;

    // field widths
    localparam int PIX_W      = 11;
    localparam int ITER_W     = 16;
    localparam int ADDR_W     = 25;
    localparam int PHASE_W    = 24;
    localparam int BPP_W      = 3;
    localparam int LINE_W     = 15;
    localparam int TAB_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // palette constants
    localparam logic [7:0] CH_GAIN = 8'd127;
    localparam logic [7:0] CH_BIAS = 8'd160;

    // gray band: i mod 106 by reciprocal multiply and one correction
    localparam logic [6:0]  GRAY_MOD   = 7'd106;
    localparam logic [16:0] GRAY_RECIP = 17'd79137;
    localparam int          GRAY_SHIFT = 23;
    localparam int          GRAY_Q_W   = 10;

    // configuration reset values
    localparam logic [PHASE_W-1:0] RST_PHASE_STEP    = 24'd167772;
    localparam logic [PHASE_W-1:0] RST_COLOUR_OFFSET = 24'd5592405;
    localparam logic [ITER_W-1:0]  RST_ITER_LIMIT    = 16'd50;
    localparam logic [BPP_W-1:0]   RST_BYTES_PER_PIX = 3'd4;
    localparam logic [LINE_W-1:0]  RST_LINE_BYTES    = 15'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP    = 3'd0,
        CFG_COLOUR_OFFSET = 3'd1,
        CFG_ITER_LIMIT    = 3'd2,
        CFG_BYTES_PER_PIX = 3'd3,
        CFG_LINE_BYTES    = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        REQ_RAINBOW = 1'b0,
        REQ_GRAY    = 1'b1
    } t_req_type;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_step;
        logic [PHASE_W-1:0] colour_offset;
        logic [ITER_W-1:0]  iteration_limit;
        logic [BPP_W-1:0]   bytes_per_pixel;
        logic [LINE_W-1:0]  line_bytes;
    } t_cfg;

    typedef struct packed {
        t_req_type         req_type;
        logic [PIX_W-1:0]  pixel_x;
        logic [PIX_W-1:0]  pixel_y;
        logic [ITER_W-1:0] iter_count;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic [7:0]        byte_low;
        logic [7:0]        byte_mid;
        logic [7:0]        byte_high;
    } t_out_item;

endpackage

// ----- sv/fpcm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// fpcm_cfg_regs
// Configuration register file; takes one write per cycle, never stalls.
// ----------------------------------------------------------------------------
module fpcm_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fpcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fpcm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output fpcm_pkg::t_cfg                 o_cfg
);
    import fpcm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // decode the write; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PHASE_STEP:    n_cfg.phase_step      = i_cfg_data[PHASE_W-1:0];
                CFG_COLOUR_OFFSET: n_cfg.colour_offset   = i_cfg_data[PHASE_W-1:0];
                CFG_ITER_LIMIT:    n_cfg.iteration_limit = i_cfg_data[ITER_W-1:0];
                CFG_BYTES_PER_PIX: n_cfg.bytes_per_pixel = i_cfg_data[BPP_W-1:0];
                CFG_LINE_BYTES:    n_cfg.line_bytes      = i_cfg_data[LINE_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step      <= RST_PHASE_STEP;
            r_cfg.colour_offset   <= RST_COLOUR_OFFSET;
            r_cfg.iteration_limit <= RST_ITER_LIMIT;
            r_cfg.bytes_per_pixel <= RST_BYTES_PER_PIX;
            r_cfg.line_bytes      <= RST_LINE_BYTES;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- sv/fpcm_cos_rom.sv -----
// ----------------------------------------------------------------------------
// fpcm_cos_rom
// Cosine palette ROM, 160 + floor(127*cos), one registered read port.
// ----------------------------------------------------------------------------
module fpcm_cos_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic [fpcm_pkg::TAB_W-1:0] o_data
);
    import fpcm_pkg::*;

    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // shift-and-subtract quotient, evaluated only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // entry for angle a (turn/2^32) from a truncating Q30 Taylor series
    function automatic logic [TAB_W-1:0] cos_entry(input logic [63:0] a);
        logic [1:0]  quad;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] d;
        logic        odd;
        longint      sum;
        longint      c;
        longint      p;
        longint      f;
        quad = a[31:30];
        rem  = a & (Q30_ONE - 64'd1);
        x    = (rem * TWO_PI_Q30) >> 32;
        x2   = (x * x) >> 30;
        odd  = quad[0];
        term = odd ? x : Q30_ONE;
        sum  = longint'(term);
        for (int n = 1; n <= 10; n++) begin
            d    = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
            term = udiv64((term * x2) >> 30, d);
            if (n[0]) sum = sum - longint'(term);
            else      sum = sum + longint'(term);
        end
        c = (quad == 2'd1 || quad == 2'd2) ? -sum : sum;
        p = longint'(CH_GAIN) * c;
        f = p >>> 30;
        return TAB_W'(longint'(CH_BIAS) + f);
    endfunction

    logic [TAB_W-1:0] rom_data [DEPTH];
    logic [TAB_W-1:0] r_data;

    // constant contents
    for (genvar k = 0; k < DEPTH; k++) begin : g_rom
        localparam logic [63:0]      ANGLE = (64'(k) << 32) / DEPTH;
        localparam logic [TAB_W-1:0] ENTRY = cos_entry(ANGLE);
        assign rom_data[k] = ENTRY;
    end

    // registered read, hold while the next stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= rom_data[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ----- sv/fractal_pixel_colour_mapper_core.sv -----
// ----------------------------------------------------------------------------
// fractal_pixel_colour_mapper_core
// Each item passes, in order, the input, phase/address, table index, palette ROM and output registers.
// Throughput: one item per cycle while the output is not stalled; each palette channel has its own ROM port.
// Reset clears all stage valid bits and loads the register defaults; the
// palette is a constant ROM, so no fill pass follows reset.
// ----------------------------------------------------------------------------
`include "fractal_pixel_colour_mapper_core_assert.svh"

module fractal_pixel_colour_mapper_core #(
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int COORD_WIDTH     = 11
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel items in
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fpcm_pkg::t_in_item              i_in_item,
    // result items out
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fpcm_pkg::t_out_item             o_out_item,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fpcm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpcm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fpcm_pkg::*;

    localparam int NSTG  = 5;
    localparam int DEP_W = $clog2(COS_TABLE_DEPTH);
    localparam int XW    = (COORD_WIDTH < PIX_W) ? COORD_WIDTH : PIX_W;
    localparam logic [DEP_W:0] DEPTH_C = (DEP_W + 1)'(COS_TABLE_DEPTH);

    t_cfg cfg;

    fpcm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // pipeline flow control: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_valid;
    logic [NSTG-1:0] n_valid;
    logic [NSTG-1:0] ld;
    logic            accept;

    always_comb begin
        ld[NSTG-1] = !r_valid[NSTG-1] || !i_out_stall;
        for (int s = NSTG - 2; s >= 0; s--) begin
            ld[s] = !r_valid[s] || ld[s+1];
        end
    end

    assign o_in_stall = !ld[0];
    assign accept     = i_in_valid && ld[0];

    always_comb begin
        n_valid = r_valid;
        if (ld[0]) n_valid[0] = accept;
        for (int s = 1; s < NSTG; s++) begin
            if (ld[s]) n_valid[s] = r_valid[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    t_in_item r_s0_item;

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s0_item <= i_in_item;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: phase product, address, gray quotient estimate, flags
    // ------------------------------------------------------------------
    logic [XW-1:0]         x_used;
    logic [XW-1:0]         y_used;
    logic [ITER_W:0]       iter_inc;
    logic [PHASE_W+ITER_W:0] phase_prod;
    logic [ADDR_W:0]       addr_sum;
    logic [ITER_W+16:0]    gq_prod;

    logic [PHASE_W-1:0]  n_s1_phase,  r_s1_phase;
    logic [ADDR_W-1:0]   n_s1_addr,   r_s1_addr;
    logic [GRAY_Q_W-1:0] n_s1_q,      r_s1_q;
    logic [ITER_W-1:0]   r_s1_iter;
    t_req_type           r_s1_mode;
    logic                n_s1_black,  r_s1_black;
    logic                n_s1_gok,    r_s1_gok;

    always_comb begin
        x_used     = r_s0_item.pixel_x[XW-1:0];
        y_used     = r_s0_item.pixel_y[XW-1:0];
        iter_inc   = (ITER_W + 1)'(r_s0_item.iter_count) + (ITER_W + 1)'(1);
        phase_prod = (PHASE_W + ITER_W + 1)'(cfg.phase_step)
                   * (PHASE_W + ITER_W + 1)'(iter_inc);
        n_s1_phase = phase_prod[PHASE_W-1:0];
        addr_sum   = (ADDR_W + 1)'(x_used) * (ADDR_W + 1)'(cfg.bytes_per_pixel)
                   + (ADDR_W + 1)'(y_used) * (ADDR_W + 1)'(cfg.line_bytes);
        n_s1_addr  = addr_sum[ADDR_W-1:0];
        gq_prod    = (ITER_W + 17)'(r_s0_item.iter_count) * (ITER_W + 17)'(GRAY_RECIP);
        n_s1_q     = GRAY_Q_W'(gq_prod >> GRAY_SHIFT);
        n_s1_black = (r_s0_item.iter_count == cfg.iteration_limit);
        n_s1_gok   = (r_s0_item.iter_count < cfg.iteration_limit);
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_s1_phase <= n_s1_phase;
            r_s1_addr  <= n_s1_addr;
            r_s1_q     <= n_s1_q;
            r_s1_iter  <= r_s0_item.iter_count;
            r_s1_mode  <= r_s0_item.req_type;
            r_s1_black <= n_s1_black;
            r_s1_gok   <= n_s1_gok;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: channel angles to table index, gray remainder
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]       ang [3];
    logic [PHASE_W+DEP_W:0]   idx_prod [3];
    logic [DEP_W-1:0]         n_s2_idx [3];
    logic [DEP_W-1:0]         r_s2_idx [3];
    logic [ITER_W-1:0]        q_mul;
    logic [ITER_W-1:0]        g_rem;
    logic [6:0]               n_s2_gray, r_s2_gray;
    logic [ADDR_W-1:0]        r_s2_addr;
    t_req_type                r_s2_mode;
    logic                     r_s2_black;
    logic                     r_s2_gok;

    always_comb begin
        ang[0] = r_s1_phase;
        ang[1] = r_s1_phase + cfg.colour_offset;
        ang[2] = r_s1_phase + {cfg.colour_offset[PHASE_W-2:0], 1'b0};
        for (int n = 0; n < 3; n++) begin
            idx_prod[n] = (PHASE_W + DEP_W + 1)'(ang[n]) * (PHASE_W + DEP_W + 1)'(DEPTH_C);
            n_s2_idx[n] = idx_prod[n][PHASE_W +: DEP_W];
        end
        q_mul = ITER_W'(ITER_W'(r_s1_q) * ITER_W'(GRAY_MOD));
        g_rem = r_s1_iter - q_mul;
        // the estimate may be one low: subtract once more
        if (g_rem >= ITER_W'(GRAY_MOD)) begin
            g_rem = g_rem - ITER_W'(GRAY_MOD);
        end
        n_s2_gray = g_rem[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            for (int n = 0; n < 3; n++) begin
                r_s2_idx[n] <= n_s2_idx[n];
            end
            r_s2_gray  <= n_s2_gray;
            r_s2_addr  <= r_s1_addr;
            r_s2_mode  <= r_s1_mode;
            r_s2_black <= r_s1_black;
            r_s2_gok   <= r_s1_gok;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: palette lookup, one ROM per channel
    // ------------------------------------------------------------------
    logic [TAB_W-1:0] ch_data [3];
    logic [ADDR_W-1:0] r_s3_addr;
    logic [6:0]        r_s3_gray;
    t_req_type         r_s3_mode;
    logic              r_s3_black;
    logic              r_s3_gok;

    for (genvar n = 0; n < 3; n++) begin : g_ch
        fpcm_cos_rom #(
            .DEPTH (COS_TABLE_DEPTH)
        ) u_rom (
            .i_clk  (i_clk),
            .i_en   (ld[3]),
            .i_addr (r_s2_idx[n]),
            .o_data (ch_data[n])
        );
    end

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_s3_addr  <= r_s2_addr;
            r_s3_gray  <= r_s2_gray;
            r_s3_mode  <= r_s2_mode;
            r_s3_black <= r_s2_black;
            r_s3_gok   <= r_s2_gok;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: pack colour, select mode, output register
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] colour;
    logic [7:0]        gray_byte;
    t_out_item         n_out, r_out;

    always_comb begin
        // red*65536 + blue*256 + green, carries kept
        colour    = (ADDR_W'(ch_data[0]) << 16) + (ADDR_W'(ch_data[2]) << 8)
                  + ADDR_W'(ch_data[1]);
        gray_byte = r_s3_gok ? {1'b0, r_s3_gray} : 8'd0;
        n_out.byte_address = r_s3_addr;
        case (r_s3_mode)
            REQ_RAINBOW: begin
                if (r_s3_black) begin
                    n_out.byte_low  = 8'd0;
                    n_out.byte_mid  = 8'd0;
                    n_out.byte_high = 8'd0;
                end else begin
                    n_out.byte_low  = colour[7:0];
                    n_out.byte_mid  = colour[15:8];
                    n_out.byte_high = colour[23:16];
                end
            end
            REQ_GRAY: begin
                n_out.byte_low  = gray_byte;
                n_out.byte_mid  = gray_byte;
                n_out.byte_high = gray_byte;
            end
            default: begin
                n_out.byte_low  = 8'd0;
                n_out.byte_mid  = 8'd0;
                n_out.byte_high = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid[NSTG-1];
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `FPCM_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid)
    `FPCM_ASSERT(a_stall_full, i_clk, i_rst_n, o_in_stall |-> (&r_valid))
    `FPCM_ASSERT(a_move_out, i_clk, i_rst_n, (r_valid[NSTG-2] && ld[NSTG-1]) |=> o_out_valid)
    `FPCM_ASSERT(a_gray_range, i_clk, i_rst_n, r_valid[2] |-> (r_s2_gray < GRAY_MOD))

endmodule
